// ----- hw/rtl/ped_pkg.sv -----
// Package for the packet envelope deframer.
// Holds header layout constants, status and register codes, and the shared structs.
// No dependencies.
package ped_pkg;

  // Header layout, in byte offsets from the start of the packet.
  localparam int unsigned HEADER_BYTES = 28;
  localparam int unsigned OFS_VERSION  = 4;
  localparam int unsigned OFS_KIND     = 6;
  localparam int unsigned OFS_LENGTH   = 8;
  localparam int unsigned OFS_SESSION  = 12;
  localparam int unsigned OFS_SEQUENCE = 20;

  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Reset values of the configuration registers.
  localparam logic [31:0] RST_MAGIC      = 32'd0;
  localparam logic [15:0] RST_VERSION    = 16'd1;
  localparam logic [31:0] RST_MAX_LENGTH = 32'd65536;
  localparam logic [15:0] RST_KIND_MASK  = 16'd511;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAGIC      = 2'd0,
    REG_VERSION    = 2'd1,
    REG_MAX_LENGTH = 2'd2,
    REG_KIND_MASK  = 2'd3
  } cfg_reg_t;

  // Packet status codes, in check order.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_MAGIC     = 3'd2,
    ST_VERSION   = 3'd3,
    ST_KIND      = 3'd4,
    ST_TOO_LARGE = 3'd5,
    ST_TRUNCATED = 3'd6,
    ST_TRAILING  = 3'd7
  } status_t;

  // Current configuration as seen by the parser.
  typedef struct packed {
    logic [31:0] expected_magic;
    logic [15:0] expected_version;
    logic [31:0] max_payload_length;
    logic [15:0] known_kind_mask;
  } cfg_t;

  // One result request.
  typedef struct packed {
    logic        has_payload_byte;
    logic [7:0]  payload_byte;
    logic        packet_done;
    status_t     status;
    logic [15:0] header_version;
    logic [15:0] message_kind;
    logic [31:0] payload_length;
    logic [63:0] session_id;
    logic [63:0] sequence_number;
  } result_t;

endpackage

// ----- hw/rtl/ped_cfg_regs.sv -----
// Configuration register file of the packet envelope deframer.
// Depends on ped_pkg for register indexes, reset values and cfg_t.
module ped_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ped_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ped_pkg::CFG_DATA_W-1:0] cfg_data,
  output ped_pkg::cfg_t                 cfg
);

  ped_pkg::cfg_t regs;

  // Decode the index and update one register per write.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.expected_magic     <= ped_pkg::RST_MAGIC;
      regs.expected_version   <= ped_pkg::RST_VERSION;
      regs.max_payload_length <= ped_pkg::RST_MAX_LENGTH;
      regs.known_kind_mask    <= ped_pkg::RST_KIND_MASK;
    end else if (cfg_we) begin
      unique case (ped_pkg::cfg_reg_t'(cfg_index))
        ped_pkg::REG_MAGIC:      regs.expected_magic     <= cfg_data;
        ped_pkg::REG_VERSION:    regs.expected_version   <= cfg_data[15:0];
        ped_pkg::REG_MAX_LENGTH: regs.max_payload_length <= cfg_data;
        ped_pkg::REG_KIND_MASK:  regs.known_kind_mask    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ----- hw/rtl/ped_parse.sv -----
// Header capture, byte counter and per-byte result logic of the deframer.
// Depends on ped_pkg for the header layout, status codes, cfg_t and result_t.
module ped_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             end_of_packet,
  input  ped_pkg::cfg_t    cfg,
  output logic             has_result,
  output ped_pkg::result_t result
);

  localparam logic [ped_pkg::COUNT_W-1:0] POS_VERSION =
    ped_pkg::COUNT_W'(ped_pkg::OFS_VERSION);
  localparam logic [ped_pkg::COUNT_W-1:0] POS_KIND =
    ped_pkg::COUNT_W'(ped_pkg::OFS_KIND);
  localparam logic [ped_pkg::COUNT_W-1:0] POS_LENGTH =
    ped_pkg::COUNT_W'(ped_pkg::OFS_LENGTH);
  localparam logic [ped_pkg::COUNT_W-1:0] POS_SESSION =
    ped_pkg::COUNT_W'(ped_pkg::OFS_SESSION);
  localparam logic [ped_pkg::COUNT_W-1:0] POS_SEQUENCE =
    ped_pkg::COUNT_W'(ped_pkg::OFS_SEQUENCE);
  localparam logic [ped_pkg::COUNT_W-1:0] POS_HEADER =
    ped_pkg::COUNT_W'(ped_pkg::HEADER_BYTES);

  logic [ped_pkg::COUNT_W-1:0] byte_count, byte_count_next;
  logic [31:0] magic_shift, magic_shift_next;
  logic [15:0] version_shift, version_shift_next;
  logic [15:0] kind_shift, kind_shift_next;
  logic [31:0] length_shift, length_shift_next;
  logic [63:0] session_shift, session_shift_next;
  logic [63:0] sequence_shift, sequence_shift_next;

  logic                        kind_ok;
  logic                        header_ok;
  logic                        pass;
  logic [ped_pkg::COUNT_W-1:0] payload_pos;
  logic [ped_pkg::COUNT_W:0]   expect_size;
  logic [ped_pkg::COUNT_W:0]   size_ext;
  ped_pkg::status_t            status;

  // Shift the byte into the header field that owns its position.
  always_comb begin
    magic_shift_next    = magic_shift;
    version_shift_next  = version_shift;
    kind_shift_next     = kind_shift;
    length_shift_next   = length_shift;
    session_shift_next  = session_shift;
    sequence_shift_next = sequence_shift;
    if (byte_count < POS_VERSION) begin
      magic_shift_next = {magic_shift[23:0], data_byte};
    end else if (byte_count < POS_KIND) begin
      version_shift_next = {version_shift[7:0], data_byte};
    end else if (byte_count < POS_LENGTH) begin
      kind_shift_next = {kind_shift[7:0], data_byte};
    end else if (byte_count < POS_SESSION) begin
      length_shift_next = {length_shift[23:0], data_byte};
    end else if (byte_count < POS_SEQUENCE) begin
      session_shift_next = {session_shift[55:0], data_byte};
    end else if (byte_count < POS_HEADER) begin
      sequence_shift_next = {sequence_shift[55:0], data_byte};
    end
  end

  // The counter saturates at its top value.
  assign byte_count_next = (&byte_count) ? byte_count : byte_count + 1'b1;

  // Header checks on the fields as they stand after this byte.
  assign kind_ok = (kind_shift_next[15:4] == 12'd0) &&
                   cfg.known_kind_mask[kind_shift_next[3:0]];
  assign header_ok = (magic_shift_next == cfg.expected_magic) &&
                     (version_shift_next == cfg.expected_version) && kind_ok &&
                     (length_shift_next <= cfg.max_payload_length);

  // Payload bytes pass while inside the declared length of a good header.
  assign payload_pos = byte_count - POS_HEADER;
  assign pass = (byte_count >= POS_HEADER) && header_ok &&
                (payload_pos < length_shift);

  // Status of the packet, evaluated on its final byte.
  assign size_ext    = {1'b0, byte_count_next};
  assign expect_size = {1'b0, length_shift_next} + {1'b0, POS_HEADER};

  always_comb begin
    if (byte_count_next < POS_HEADER) begin
      status = ped_pkg::ST_SHORT;
    end else if (magic_shift_next != cfg.expected_magic) begin
      status = ped_pkg::ST_MAGIC;
    end else if (version_shift_next != cfg.expected_version) begin
      status = ped_pkg::ST_VERSION;
    end else if (!kind_ok) begin
      status = ped_pkg::ST_KIND;
    end else if (length_shift_next > cfg.max_payload_length) begin
      status = ped_pkg::ST_TOO_LARGE;
    end else if (size_ext < expect_size) begin
      status = ped_pkg::ST_TRUNCATED;
    end else if (size_ext > expect_size) begin
      status = ped_pkg::ST_TRAILING;
    end else begin
      status = ped_pkg::ST_OK;
    end
  end

  // Assemble the result; fields not carried are zero.
  always_comb begin
    has_result = pass || end_of_packet;
    result = '0;
    result.has_payload_byte = pass;
    result.payload_byte     = pass ? data_byte : 8'd0;
    if (end_of_packet) begin
      result.packet_done = 1'b1;
      result.status      = status;
      if (status != ped_pkg::ST_SHORT) begin
        result.header_version  = version_shift_next;
        result.message_kind    = kind_shift_next;
        result.payload_length  = length_shift_next;
        result.session_id      = session_shift_next;
        result.sequence_number = sequence_shift_next;
      end
    end
  end

  // Packet state advances per byte and clears after the final byte.
  always_ff @(posedge clk) begin
    if (rst || (step && end_of_packet)) begin
      byte_count     <= '0;
      magic_shift    <= '0;
      version_shift  <= '0;
      kind_shift     <= '0;
      length_shift   <= '0;
      session_shift  <= '0;
      sequence_shift <= '0;
    end else if (step) begin
      byte_count     <= byte_count_next;
      magic_shift    <= magic_shift_next;
      version_shift  <= version_shift_next;
      kind_shift     <= kind_shift_next;
      length_shift   <= length_shift_next;
      session_shift  <= session_shift_next;
      sequence_shift <= sequence_shift_next;
    end
  end

endmodule

// ----- hw/rtl/ped_result_reg.sv -----
// Output register of the deframer; holds one result request until taken.
// Depends on ped_pkg for result_t.
module ped_result_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ped_pkg::result_t result_in,
  input  logic             out_stall,
  output logic             out_valid,
  output ped_pkg::result_t result_out
);

  // Valid flag: set on load, cleared once the request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

// ----- hw/rtl/packet_envelope_deframer_core.sv -----
// Flow: an accepted byte is held in the input register and parsed combinationally; its result
// is loaded into the output register when the byte moves on, which a stalled result can delay.
// Throughput: one byte per cycle through the input register and the output register;
// only a stalled result that blocks a new one holds the input.
// Reset: synchronous; clears the packet state, handshake flags and loads register defaults.
// Depends on ped_pkg, ped_cfg_regs, ped_parse and ped_result_reg.
module packet_envelope_deframer_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ped_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ped_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     data_byte,
  input  logic                           end_of_packet,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           has_payload_byte,
  output logic [7:0]                     payload_byte,
  output logic                           packet_done,
  output logic [2:0]                     status,
  output logic [15:0]                    header_version,
  output logic [15:0]                    message_kind,
  output logic [31:0]                    payload_length,
  output logic [63:0]                    session_id,
  output logic [63:0]                    sequence_number
);

  ped_pkg::cfg_t    cfg;
  ped_pkg::result_t result_next;
  ped_pkg::result_t result_q;

  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       in_q_eop;
  logic       has_result;
  logic       step;
  logic       load;
  logic       in_accept;

  ped_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held byte moves on unless its result would overwrite a stalled one.
  assign step      = in_q_valid && (!has_result || !out_valid || !out_stall);
  assign load      = step && has_result;
  assign in_stall  = in_q_valid && !step;
  assign in_accept = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_accept) begin
      in_q_valid <= 1'b1;
    end else if (step) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_q_byte <= data_byte;
      in_q_eop  <= end_of_packet;
    end
  end

  ped_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .data_byte     (in_q_byte),
    .end_of_packet (in_q_eop),
    .cfg           (cfg),
    .has_result    (has_result),
    .result        (result_next)
  );

  ped_result_reg u_result_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .result_in  (result_next),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .result_out (result_q)
  );

  // Output fields.
  assign has_payload_byte = result_q.has_payload_byte;
  assign payload_byte     = result_q.payload_byte;
  assign packet_done      = result_q.packet_done;
  assign status           = result_q.status;
  assign header_version   = result_q.header_version;
  assign message_kind     = result_q.message_kind;
  assign payload_length   = result_q.payload_length;
  assign session_id       = result_q.session_id;
  assign sequence_number  = result_q.sequence_number;

  // A new result never replaces one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> !(out_valid && out_stall))
    else $error("result loaded over a stalled request");

  // Input is held back only while a byte waits in the input register.
  a_stall_needs_byte: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_q_valid)
    else $error("input stalled with an empty input register");

  // A result that does not end a packet carries status ok.
  a_status_mid_packet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !packet_done) |-> (status == ped_pkg::ST_OK))
    else $error("nonzero status outside a final byte");

  // A short packet reports no header fields.
  a_short_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && packet_done && status == ped_pkg::ST_SHORT) |->
      (session_id == 64'd0 && payload_length == 32'd0))
    else $error("short packet reported header fields");

endmodule

// ----- tb/sv/packet_envelope_deframer_core_tb.sv -----
// Self-checking testbench for packet_envelope_deframer_core: sends byte streams of packets
// and compares every result against an in-bench deframing predictor.
// Depends on ped_pkg and the packet_envelope_deframer_core RTL.
module packet_envelope_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ped_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_BYTES = 850;
  localparam int unsigned DRAIN_CYCLES = 6;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            data_byte = '0;
  logic                  end_of_packet = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  has_payload_byte;
  logic [7:0]            payload_byte;
  logic                  packet_done;
  logic [2:0]            status;
  logic [15:0]           header_version;
  logic [15:0]           message_kind;
  logic [31:0]           payload_length;
  logic [63:0]           session_id;
  logic [63:0]           sequence_number;

  // Predictor copy of the configuration registers.
  logic [31:0] cfg_magic;
  logic [15:0] cfg_version;
  logic [31:0] cfg_max_len;
  logic [15:0] cfg_kind_mask;

  // Predictor copy of the per-packet parse state.
  logic [31:0] pkt_bytes;
  logic [31:0] hdr_magic;
  logic [15:0] hdr_version;
  logic [15:0] hdr_kind;
  logic [31:0] hdr_length;
  logic [63:0] hdr_session;
  logic [63:0] hdr_sequence;

  result_t     predicted_reports[$];
  int          mismatch_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int unsigned rx_hold = 0;

  packet_envelope_deframer_core uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Deframing predictor.
  function automatic bit kind_known(input logic [15:0] kind);
    return (kind <= 16'd15) && cfg_kind_mask[kind[3:0]];
  endfunction

  function automatic bit header_good();
    return (hdr_magic == cfg_magic) && (hdr_version == cfg_version) &&
           kind_known(hdr_kind) && (hdr_length <= cfg_max_len);
  endfunction

  function automatic void clear_packet();
    pkt_bytes    = '0;
    hdr_magic    = '0;
    hdr_version  = '0;
    hdr_kind     = '0;
    hdr_length   = '0;
    hdr_session  = '0;
    hdr_sequence = '0;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, input logic eop);
    logic [31:0] pos;
    logic [32:0] pkt_size;
    logic [32:0] want_size;
    bit          pass;
    status_t     st;
    result_t     r;
    pos  = pkt_bytes;
    pass = 1'b0;
    // Shift the byte into whichever header field covers its offset.
    if (pos < OFS_VERSION) begin
      hdr_magic = {hdr_magic[23:0], b};
    end else if (pos < OFS_KIND) begin
      hdr_version = {hdr_version[7:0], b};
    end else if (pos < OFS_LENGTH) begin
      hdr_kind = {hdr_kind[7:0], b};
    end else if (pos < OFS_SESSION) begin
      hdr_length = {hdr_length[23:0], b};
    end else if (pos < OFS_SEQUENCE) begin
      hdr_session = {hdr_session[55:0], b};
    end else if (pos < HEADER_BYTES) begin
      hdr_sequence = {hdr_sequence[55:0], b};
    end else begin
      pass = header_good() && ((pos - HEADER_BYTES) < hdr_length);
    end
    // The byte counter sticks at its top value.
    if (pkt_bytes != '1) begin
      pkt_bytes = pkt_bytes + 32'd1;
    end
    if (!(pass || eop)) begin
      return;
    end
    r = '0;
    if (pass) begin
      r.has_payload_byte = 1'b1;
      r.payload_byte     = b;
    end
    if (eop) begin
      pkt_size  = {1'b0, pkt_bytes};
      want_size = 33'(HEADER_BYTES) + {1'b0, hdr_length};
      if (pkt_size < 33'(HEADER_BYTES)) begin
        st = ST_SHORT;
      end else if (hdr_magic != cfg_magic) begin
        st = ST_MAGIC;
      end else if (hdr_version != cfg_version) begin
        st = ST_VERSION;
      end else if (!kind_known(hdr_kind)) begin
        st = ST_KIND;
      end else if (hdr_length > cfg_max_len) begin
        st = ST_TOO_LARGE;
      end else if (pkt_size < want_size) begin
        st = ST_TRUNCATED;
      end else if (pkt_size > want_size) begin
        st = ST_TRAILING;
      end else begin
        st = ST_OK;
      end
      r.packet_done = 1'b1;
      r.status      = st;
      // A short packet reports no header fields at all.
      if (st != ST_SHORT) begin
        r.header_version  = hdr_version;
        r.message_kind    = hdr_kind;
        r.payload_length  = hdr_length;
        r.session_id      = hdr_session;
        r.sequence_number = hdr_sequence;
      end
      clear_packet();
    end
    predicted_reports = {predicted_reports, r};
  endfunction

  // Sends one byte request; valid stays high when the next byte follows without a gap.
  task automatic send_byte(input logic [7:0] b, input logic eop);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_packet <= eop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_byte(b, eop);
    bytes_sent++;
  endtask

  // Sends a packet of total bytes: the header first, random payload after it.
  task automatic send_packet(input logic [31:0] magic, input logic [15:0] version,
                             input logic [15:0] kind, input logic [31:0] length,
                             input logic [63:0] sid, input logic [63:0] seq,
                             input int unsigned total);
    logic [223:0] hdr;
    logic [7:0]   b;
    hdr      = {magic, version, kind, length, sid, seq};
    tx_burst = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < total; i++) begin
      b = (i < HEADER_BYTES) ? hdr[223 - 8 * i -: 8] : 8'($urandom);
      send_byte(b, i == total - 1);
    end
  endtask

  // Lets every outstanding result drain and the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers back to back while the block is idle.
  // The upper data bits of the 16-bit registers carry noise that must be ignored.
  task automatic write_registers(input logic [31:0] magic, input logic [15:0] version,
                                 input logic [31:0] max_len, input logic [15:0] mask);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAGIC;
    cfg_data  <= magic;
    @(posedge clk);
    cfg_index <= REG_VERSION;
    cfg_data  <= {16'($urandom), version};
    @(posedge clk);
    cfg_index <= REG_MAX_LENGTH;
    cfg_data  <= max_len;
    @(posedge clk);
    cfg_index <= REG_KIND_MASK;
    cfg_data  <= {16'($urandom), mask};
    @(posedge clk);
    cfg_we        <= 1'b0;
    cfg_magic     = magic;
    cfg_version   = version;
    cfg_max_len   = max_len;
    cfg_kind_mask = mask;
  endtask

  // Each status code under the reset configuration, plus field extremes.
  task automatic test_status_checks();
    send_packet(32'hFFFF_FFFF, 16'd1, 16'd0, 32'd0, '1, '1, 1);
    send_packet(32'd0, 16'd1, 16'd0, 32'd0, '1, '1, 27);
    send_packet(32'd0, 16'd1, 16'd0, 32'd0, '0, '0, 28);
    send_packet(32'd0, 16'd1, 16'd8, 32'd4, '1, '1, 32);
    send_packet(32'd1, 16'd1, 16'd0, 32'd2, '1, '0, 30);
    send_packet(32'd0, 16'd2, 16'd0, 32'd2, '0, '1, 30);
    send_packet(32'd0, 16'hFFFF, 16'd0, 32'd0, '1, '1, 28);
    send_packet(32'hDEAD_BEEF, 16'd7, 16'd3, 32'd1, '1, '1, 29);
    send_packet(32'd0, 16'd1, 16'd9, 32'd1, '1, '1, 29);
    send_packet(32'd0, 16'd1, 16'd16, 32'd1, '1, '1, 29);
    send_packet(32'd0, 16'd1, 16'hFFFF, 32'd1, '1, '1, 29);
    send_packet(32'd0, 16'd1, 16'd1, 32'd65537, '1, '1, 31);
    send_packet(32'd0, 16'd1, 16'd2, 32'd65536, '1, '1, 29);
    send_packet(32'd0, 16'd1, 16'd4, 32'd5, '1, '1, 30);
    send_packet(32'd0, 16'd1, 16'd5, 32'd2, '1, '1, 33);
    send_packet(32'd0, 16'd1, 16'd6, 32'hFFFF_FFFF, '1, '1, 28);
  endtask

  // Register extremes: all-ones magic and version, zero and full length limits, empty mask.
  task automatic test_register_settings();
    write_registers(32'hFFFF_FFFF, 16'hFFFF, 32'd0, 16'hFFFF);
    send_packet(32'hFFFF_FFFF, 16'hFFFF, 16'd15, 32'd0, '1, '1, 28);
    send_packet(32'hFFFF_FFFF, 16'hFFFF, 16'd0, 32'd1, '1, '1, 29);
    send_packet(32'hFFFF_FFFF, 16'hFFFF, 16'd16, 32'd0, '1, '1, 28);
    write_registers(32'd0, 16'd0, 32'hFFFF_FFFF, 16'h0000);
    send_packet(32'd0, 16'd0, 16'd0, 32'd3, '1, '1, 31);
    write_registers(32'h8000_0001, 16'h8000, 32'hFFFF_FFFF, 16'h8000);
    send_packet(32'h8000_0001, 16'h8000, 16'd15, 32'hFFFF_FFFF, '1, '1, 40);
    send_packet(32'h8000_0001, 16'h8000, 16'd14, 32'd2, '1, '1, 30);
    send_packet(32'h8000_0001, 16'h8000, 16'd15, 32'd3, '0, '0, 31);
    write_registers(RST_MAGIC, RST_VERSION, RST_MAX_LENGTH, RST_KIND_MASK);
  endtask

  // Random traffic under changing configurations: mostly well-formed packets,
  // some with one broken header field, the rest plain noise.
  task automatic test_random_traffic();
    int unsigned first_byte;
    int unsigned pkt_index;
    int unsigned roll;
    int unsigned total;
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] kind;
    logic [31:0] len;
    logic [31:0] max_len;
    logic [15:0] mask;
    first_byte = bytes_sent;
    pkt_index  = 0;
    while (bytes_sent < first_byte + RANDOM_BYTES) begin
      if (pkt_index % 8 == 0) begin
        case ($urandom_range(0, 3))
          0:       max_len = $urandom_range(0, 12);
          1:       max_len = RST_MAX_LENGTH;
          2:       max_len = 32'hFFFF_FFFF;
          default: max_len = $urandom;
        endcase
        mask = ($urandom_range(0, 7) == 0) ? 16'h0000 :
               (16'($urandom) | (16'd1 << $urandom_range(0, 15)));
        write_registers($urandom, 16'($urandom), max_len, mask);
      end
      pkt_index++;
      roll    = $urandom_range(0, 99);
      magic   = cfg_magic;
      version = cfg_version;
      len     = $urandom_range(0, 16);
      if (len > cfg_max_len) begin
        len = cfg_max_len;
      end
      kind = 16'($urandom_range(0, 15));
      repeat (16) begin
        if (!cfg_kind_mask[kind[3:0]]) begin
          kind = 16'($urandom_range(0, 15));
        end
      end
      total = HEADER_BYTES + len;
      if (roll < 70) begin
        // Well-formed header; now and then the packet ends early or runs long.
        case ($urandom_range(0, 9))
          0:       total = total - $urandom_range(1, 3);
          1:       total = total + $urandom_range(1, 3);
          default: ;
        endcase
      end else if (roll < 85) begin
        case ($urandom_range(0, 3))
          0:       magic = magic ^ (32'd1 << $urandom_range(0, 31));
          1:       version = version ^ (16'd1 << $urandom_range(0, 15));
          2:       kind = 16'($urandom);
          default: len = $urandom;
        endcase
        total = HEADER_BYTES + $urandom_range(0, 16);
      end else begin
        magic   = $urandom;
        version = 16'($urandom);
        kind    = 16'($urandom);
        len     = $urandom;
        total   = $urandom_range(1, 48);
      end
      send_packet(magic, version, kind, len, {$urandom, $urandom}, {$urandom, $urandom}, total);
    end
  endtask

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic check_report();
    result_t want;
    if (predicted_reports.size() == 0) begin
      $error("result request arrived with no prediction pending");
      mismatch_count++;
      return;
    end
    want = predicted_reports.pop_front();
    compare_field("has_payload_byte", 64'(want.has_payload_byte), 64'(has_payload_byte));
    compare_field("payload_byte", 64'(want.payload_byte), 64'(payload_byte));
    compare_field("packet_done", 64'(want.packet_done), 64'(packet_done));
    compare_field("status", 64'(want.status), 64'(status));
    compare_field("header_version", 64'(want.header_version), 64'(header_version));
    compare_field("message_kind", 64'(want.message_kind), 64'(message_kind));
    compare_field("payload_length", 64'(want.payload_length), 64'(payload_length));
    compare_field("session_id", want.session_id, session_id);
    compare_field("sequence_number", want.sequence_number, sequence_number);
  endtask

  // Result side: check each accepted request, then hold off for a random number of cycles.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      check_report();
      rx_hold = rx_burst ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 31) == 0) begin
        rx_burst = !rx_burst;
      end
    end else if (rx_hold > 0) begin
      rx_hold--;
    end
    out_stall <= (rx_hold > 0);
  end

  // Watchdog on total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    cfg_magic     = RST_MAGIC;
    cfg_version   = RST_VERSION;
    cfg_max_len   = RST_MAX_LENGTH;
    cfg_kind_mask = RST_KIND_MASK;
    clear_packet();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_status_checks();
    test_register_settings();
    test_random_traffic();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- packet_envelope_deframer_core.f -----
hw/rtl/ped_pkg.sv
hw/rtl/ped_cfg_regs.sv
hw/rtl/ped_parse.sv
hw/rtl/ped_result_reg.sv
hw/rtl/packet_envelope_deframer_core.sv
tb/sv/packet_envelope_deframer_core_tb.sv
